// ===== hdl/ttcb_pkg.sv =====
// Package: shared types, constants and state encoding for the terminal cell buffer.
`timescale 1ns / 1ps
package ttcb_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;
  localparam logic [7:0] BLANK = 8'h20;
  localparam int TAB_STEP = 8;

  typedef enum logic [4:0] {
    ACT_CHAR = 5'd0, ACT_CR = 5'd1, ACT_LF = 5'd2, ACT_BS = 5'd3, ACT_TAB = 5'd4,
    ACT_UP = 5'd5, ACT_DOWN = 5'd6, ACT_RIGHT = 5'd7, ACT_LEFT = 5'd8,
    ACT_POS = 5'd9, ACT_REGION = 5'd10, ACT_ERASE_LINE = 5'd11,
    ACT_ERASE_DISP = 5'd12, ACT_VIDEO = 5'd13, ACT_SHOW = 5'd14,
    ACT_HIDE = 5'd15, ACT_READ = 5'd16
  } action_t;

  localparam logic [7:0] VID_OFF = 8'd0;
  localparam logic [7:0] VID_BOLD = 8'd1;
  localparam logic [7:0] VID_UNDER = 8'd4;
  localparam logic [7:0] VID_INV = 8'd7;
  localparam logic [7:0] MODE_TO_END = 8'd0;
  localparam logic [7:0] MODE_TO_CUR = 8'd1;
  localparam logic [7:0] MODE_ALL = 8'd2;

  typedef struct packed {
    logic [4:0] action;
    logic [7:0] code;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
  } in_req_t;

  typedef struct packed {
    logic [7:0] cell_code;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       bold_on;
    logic       inverse_on;
    logic       underline_on;
    logic       cursor_shown;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_READ_WAIT, ST_FILL, ST_SCR_RD, ST_SCR_WAIT,
    ST_SCR_WR, ST_SCR_BLANK, ST_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_req;
    logic exec;
    logic fill_start;
    logic fill_step;
    logic scr_start;
    logic scr_rd;
    logic scr_wr;
    logic scr_blank_start;
    logic read_cap;
    logic out_load;
    logic clr_step;
  } ctl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_fill;
    logic need_scroll;
    logic need_read;
    logic fill_last;
    logic scr_last_row;
    logic clr_last;
  } dp_stat_t;

endpackage

// ===== hdl/ttcb_ram.sv =====
// Generic single-port write, single-port registered read RAM.
`timescale 1ns / 1ps
module ttcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/ttcb_ctrl.sv =====
// Controller state machine sequencing commands, erases, scrolls and the clear pass.
`timescale 1ns / 1ps
module ttcb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ttcb_pkg::dp_stat_t stat,
  output ttcb_pkg::ctl_cmd_t cmd
);
  import ttcb_pkg::*;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    ovalid_nxt = ovalid_r && !out_ready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_fill) begin
          cmd.fill_start = 1'b1;
          state_nxt = ST_FILL;
        end else if (stat.need_scroll) begin
          cmd.scr_start = 1'b1;
          state_nxt = stat.scr_last_row ? ST_SCR_BLANK : ST_SCR_RD;
          if (stat.scr_last_row) cmd.scr_blank_start = 1'b1;
        end else if (stat.need_read) begin
          state_nxt = ST_READ_WAIT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ_WAIT: begin
        cmd.read_cap = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) state_nxt = ST_DONE;
      end
      ST_SCR_RD: begin
        cmd.scr_rd = 1'b1;
        state_nxt = ST_SCR_WAIT;
      end
      ST_SCR_WAIT: begin
        // hold the source address so the read data stays put for the write
        cmd.scr_rd = 1'b1;
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.scr_wr = 1'b1;
        if (stat.fill_last) begin
          cmd.scr_blank_start = 1'b1;
          state_nxt = ST_SCR_BLANK;
        end else begin
          state_nxt = ST_SCR_RD;
        end
      end
      ST_SCR_BLANK: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_r || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/ttcb_dp.sv =====
// Datapath: cursor, region, flags, address walkers and the screen memory.
`timescale 1ns / 1ps
module ttcb_dp #(
  parameter int ROWS = ttcb_pkg::ROWS_DEF,
  parameter int COLS = ttcb_pkg::COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ttcb_pkg::in_req_t  in_data,
  input  ttcb_pkg::ctl_cmd_t cmd,
  output ttcb_pkg::dp_stat_t stat,
  output ttcb_pkg::out_req_t out_data
);
  import ttcb_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW = $clog2(DEPTH);

  in_req_t    req_r;
  out_req_t   out_r;
  logic [4:0] row_r, row_nxt, top_r, top_nxt, bot_r, bot_nxt;
  logic [6:0] col_r, col_nxt;
  logic [2:0] flags_r, flags_nxt;
  logic       vis_r, vis_nxt;
  logic [7:0] cell_r;

  // walker: linear address run from ptr to end, plus scroll row walk
  logic [AW-1:0] ptr_r, end_r;
  logic [AW-1:0] fill_first, fill_final;
  logic          fill_go;
  logic [AW-1:0] src_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  ttcb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [7:0] clampv(input logic [7:0] v, input logic [7:0] hi);
    if (v == 8'd0) return 8'd1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [AW-1:0] lin(input logic [4:0] r, input logic [6:0] c);
    logic [AW+7:0] t;
    t = (AW+8)'(r - 5'd1) * (AW+8)'(COLS) + (AW+8)'(c - 7'd1);
    return t[AW-1:0];
  endfunction

  localparam logic [7:0] ROWS8 = 8'(ROWS);
  localparam logic [7:0] COLS8 = 8'(COLS);
  localparam logic [AW-1:0] LASTA = AW'(DEPTH - 1);
  localparam logic [AW-1:0] COLSA = AW'(COLS);

  // next-state logic for the command
  logic       lf_pend, do_scroll, do_write;
  logic [8:0] tmp9;
  logic [7:0] n8;
  logic [4:0] lf_row;
  logic       lf_scroll;
  logic [7:0] arg_row8, arg_col8, arg_bot8;

  assign arg_row8 = clampv(req_r.arg_first, ROWS8);
  assign arg_col8 = clampv(req_r.arg_second, COLS8);
  assign arg_bot8 = clampv(req_r.arg_second, ROWS8);

  always_comb begin
    lf_scroll = (row_r + 5'd1) > bot_r;
    lf_row    = lf_scroll ? bot_r : row_r + 5'd1;
  end

  always_comb begin
    row_nxt = row_r; col_nxt = col_r; top_nxt = top_r; bot_nxt = bot_r;
    flags_nxt = flags_r; vis_nxt = vis_r;
    do_scroll = 1'b0; do_write = 1'b0; lf_pend = 1'b0;
    fill_go = 1'b0; fill_first = '0; fill_final = '0;
    n8 = (req_r.arg_first == 8'd0) ? 8'd1 : req_r.arg_first;
    tmp9 = '0;
    unique case (req_r.action)
      ACT_CHAR: begin
        do_write = 1'b1;
        if (col_r == 7'(COLS)) begin col_nxt = 7'd1; lf_pend = 1'b1; end
        else col_nxt = col_r + 7'd1;
      end
      ACT_CR: col_nxt = 7'd1;
      ACT_LF: lf_pend = 1'b1;
      ACT_BS: if (col_r > 7'd1) col_nxt = col_r - 7'd1;
      ACT_TAB: begin
        tmp9 = 9'({(col_r - 7'd1) >> 3, 3'b000}) + 9'(TAB_STEP + 1);
        if (tmp9 > 9'(COLS)) begin col_nxt = 7'd1; lf_pend = 1'b1; end
        else col_nxt = tmp9[6:0];
      end
      ACT_UP: row_nxt = (n8 >= 8'(row_r)) ? 5'd1 : row_r - n8[4:0];
      ACT_DOWN: begin
        tmp9 = 9'(row_r) + 9'(n8);
        row_nxt = (tmp9 > 9'(ROWS)) ? 5'(ROWS) : tmp9[4:0];
      end
      ACT_RIGHT: begin
        tmp9 = 9'(col_r) + 9'(n8);
        col_nxt = (tmp9 > 9'(COLS)) ? 7'(COLS) : tmp9[6:0];
      end
      ACT_LEFT: col_nxt = (n8 >= 8'(col_r)) ? 7'd1 : col_r - n8[6:0];
      ACT_POS: begin
        row_nxt = arg_row8[4:0];
        col_nxt = arg_col8[6:0];
      end
      ACT_REGION: begin
        top_nxt = arg_row8[4:0];
        bot_nxt = arg_bot8[4:0];
        if (bot_nxt < top_nxt) bot_nxt = top_nxt;
      end
      ACT_ERASE_LINE: begin
        fill_go = 1'b1;
        if (req_r.arg_first == MODE_TO_CUR) begin
          fill_first = lin(row_r, 7'd1); fill_final = lin(row_r, col_r);
        end else if (req_r.arg_first == MODE_ALL) begin
          fill_first = lin(row_r, 7'd1); fill_final = lin(row_r, 7'(COLS));
        end else begin
          fill_first = lin(row_r, col_r); fill_final = lin(row_r, 7'(COLS));
        end
      end
      ACT_ERASE_DISP: begin
        if (req_r.arg_first == MODE_TO_END) begin
          fill_go = 1'b1; fill_first = lin(row_r, col_r); fill_final = LASTA;
        end else if (req_r.arg_first == MODE_TO_CUR) begin
          fill_go = 1'b1; fill_first = '0; fill_final = lin(row_r, col_r);
        end else if (req_r.arg_first == MODE_ALL) begin
          fill_go = 1'b1; fill_first = '0; fill_final = LASTA;
        end
      end
      ACT_VIDEO: begin
        if (req_r.arg_first == VID_INV) flags_nxt[1] = 1'b1;
        else if (req_r.arg_first == VID_BOLD) flags_nxt[0] = 1'b1;
        else if (req_r.arg_first == VID_UNDER) flags_nxt[2] = 1'b1;
        else if (req_r.arg_first == VID_OFF) flags_nxt = 3'b000;
      end
      ACT_SHOW: vis_nxt = 1'b1;
      ACT_HIDE: vis_nxt = 1'b0;
      default: ;
    endcase
    if (lf_pend) begin
      row_nxt = lf_row;
      do_scroll = lf_scroll;
    end
  end

  assign stat.need_fill   = fill_go;
  assign stat.need_scroll = do_scroll;
  assign stat.need_read   = (req_r.action == ACT_READ);
  assign stat.fill_last   = (ptr_r == end_r);
  // one-line region: nothing to copy, only the bottom row is blanked
  logic [AW-1:0] bot_base;
  assign bot_base = lin(bot_r, 7'd1);
  assign stat.scr_last_row = (top_r == bot_r);
  logic [AW:0] clr_ptr_r;
  assign stat.clr_last = (clr_ptr_r == (AW+1)'(DEPTH - 1));

  // memory port selection
  always_comb begin
    we = 1'b0; waddr = ptr_r; wdata = BLANK;
    raddr = lin(arg_row8[4:0], arg_col8[6:0]);
    if (cmd.clr_step) begin
      we = 1'b1; waddr = clr_ptr_r[AW-1:0];
    end else if (cmd.exec && do_write) begin
      we = 1'b1; waddr = lin(row_r, col_r); wdata = req_r.code;
    end else if (cmd.fill_step) begin
      we = 1'b1;
    end else if (cmd.scr_wr) begin
      we = 1'b1; wdata = rdata;
    end
    if (cmd.scr_rd) raddr = src_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 5'd1; col_r <= 7'd1; top_r <= 5'd1; bot_r <= 5'(ROWS);
      flags_r <= '0; vis_r <= 1'b1; clr_ptr_r <= '0;
    end else begin
      if (cmd.clr_step) clr_ptr_r <= clr_ptr_r + (AW+1)'(1);
      if (cmd.exec) begin
        row_r <= row_nxt; col_r <= col_nxt; top_r <= top_nxt; bot_r <= bot_nxt;
        flags_r <= flags_nxt; vis_r <= vis_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r  <= in_data;
      cell_r <= 8'd0;
    end
    if (cmd.read_cap) cell_r <= rdata;
    if (cmd.fill_start) begin
      ptr_r <= fill_first; end_r <= fill_final;
    end else if (cmd.scr_start) begin
      if (top_r == bot_r) begin
        ptr_r <= bot_base; end_r <= bot_base + COLSA - AW'(1);
      end else begin
        ptr_r <= lin(top_r, 7'd1); src_r <= lin(top_r, 7'd1) + COLSA;
        end_r <= bot_base - AW'(1);
      end
    end else if (cmd.scr_blank_start && cmd.scr_wr) begin
      ptr_r <= bot_base; end_r <= bot_base + COLSA - AW'(1);
    end else if (cmd.fill_step || cmd.scr_wr) begin
      ptr_r <= ptr_r + AW'(1);
      src_r <= src_r + AW'(1);
    end
    if (cmd.out_load) begin
      out_r.cell_code    <= cell_r;
      out_r.cursor_row   <= row_r;
      out_r.cursor_col   <= col_r;
      out_r.bold_on      <= flags_r[0];
      out_r.inverse_on   <= flags_r[1];
      out_r.underline_on <= flags_r[2];
      out_r.cursor_shown <= vis_r;
    end
  end

  assign out_data = out_r;
endmodule

// ===== hdl/text_terminal_cell_buffer.sv =====
// Top level of the character-cell terminal screen buffer.
// A request passes the controller's execute step, a read-capture step for a read, and a
// done step that loads the registered result; no new request is taken until then, and
// the done step waits while an earlier result is not yet taken. Erases write each cleared
// cell; a scroll reads, holds and writes each moved cell, then blanks the bottom row.
// After reset a clearing pass writes spaces to all ROWS*COLS cells.
`timescale 1ns / 1ps
module text_terminal_cell_buffer #(
  parameter int ROWS = ttcb_pkg::ROWS_DEF,
  parameter int COLS = ttcb_pkg::COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ttcb_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ttcb_pkg::out_req_t out_data
);
  import ttcb_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ttcb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  ttcb_dp #(.ROWS(ROWS), .COLS(COLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
    .out_data(out_data)
  );
endmodule

// ===== test/text_terminal_cell_buffer_tb.sv =====
// Testbench: random and directed terminal commands checked against a screen predictor.
`timescale 1ns / 1ps
module text_terminal_cell_buffer_tb;
  import ttcb_pkg::*;

  localparam int NROW = 25;
  localparam int NCOL = 80;
  localparam int WATCH_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_req_t in_data;
  logic out_valid;
  logic out_ready;
  out_req_t out_data;

  text_terminal_cell_buffer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  logic [7:0] scr [NROW*NCOL];
  int cur_row, cur_col, reg_top, reg_bot;
  logic f_bold, f_inv, f_under, f_show;

  in_req_t pending_cmds[$];
  out_req_t expected_status[$];
  int send_idle_pct, recv_stall_pct;
  bit drain_hold;
  bit failed;
  int quiet_cycles;

  function automatic int sat(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void blank_cells(int r, int c0, int c1);
    for (int c = c0; c <= c1; c++) scr[(r-1)*NCOL + c-1] = BLANK;
  endfunction

  function automatic void advance_line();
    int nr;
    nr = cur_row + 1;
    if (nr > reg_bot) begin
      for (int r = reg_top; r < reg_bot; r++)
        for (int c = 0; c < NCOL; c++) scr[(r-1)*NCOL + c] = scr[r*NCOL + c];
      blank_cells(reg_bot, 1, NCOL);
      nr = reg_bot;
    end
    cur_row = sat(nr, NROW);
  endfunction

  function automatic void screen_reset();
    foreach (scr[i]) scr[i] = BLANK;
    cur_row = 1; cur_col = 1; reg_top = 1; reg_bot = NROW;
    f_bold = 0; f_inv = 0; f_under = 0; f_show = 1;
  endfunction

  function automatic out_req_t apply_command(in_req_t q);
    out_req_t o;
    int n, a1, a2;
    logic [7:0] cell_val;
    cell_val = 8'd0;
    a1 = q.arg_first;
    a2 = q.arg_second;
    n = (a1 == 0) ? 1 : a1;
    case (q.action)
      ACT_CHAR: begin
        scr[(cur_row-1)*NCOL + cur_col-1] = q.code;
        cur_col++;
        if (cur_col > NCOL) begin
          cur_col = 1;
          advance_line();
        end
      end
      ACT_CR: cur_col = 1;
      ACT_LF: advance_line();
      ACT_BS: if (cur_col > 1) cur_col--;
      ACT_TAB: begin
        n = ((cur_col - 1) / TAB_STEP + 1) * TAB_STEP + 1;
        if (n > NCOL) begin
          cur_col = 1;
          advance_line();
        end else cur_col = n;
      end
      ACT_UP: cur_row = (n >= cur_row) ? 1 : cur_row - n;
      ACT_DOWN: cur_row = sat(cur_row + n, NROW);
      ACT_RIGHT: cur_col = sat(cur_col + n, NCOL);
      ACT_LEFT: cur_col = (n >= cur_col) ? 1 : cur_col - n;
      ACT_POS: begin
        cur_row = sat(a1, NROW);
        cur_col = sat(a2, NCOL);
      end
      ACT_REGION: begin
        reg_top = sat(a1, NROW);
        reg_bot = sat(a2, NROW);
        if (reg_bot < reg_top) reg_bot = reg_top;
      end
      ACT_ERASE_LINE: begin
        if (q.arg_first == MODE_TO_CUR) blank_cells(cur_row, 1, cur_col);
        else if (q.arg_first == MODE_ALL) blank_cells(cur_row, 1, NCOL);
        else blank_cells(cur_row, cur_col, NCOL);
      end
      ACT_ERASE_DISP: begin
        if (q.arg_first == MODE_TO_END) begin
          blank_cells(cur_row, cur_col, NCOL);
          for (int r = cur_row + 1; r <= NROW; r++) blank_cells(r, 1, NCOL);
        end else if (q.arg_first == MODE_TO_CUR) begin
          for (int r = 1; r < cur_row; r++) blank_cells(r, 1, NCOL);
          blank_cells(cur_row, 1, cur_col);
        end else if (q.arg_first == MODE_ALL) begin
          foreach (scr[i]) scr[i] = BLANK;
        end
      end
      ACT_VIDEO: begin
        if (q.arg_first == VID_INV) f_inv = 1;
        else if (q.arg_first == VID_BOLD) f_bold = 1;
        else if (q.arg_first == VID_UNDER) f_under = 1;
        else if (q.arg_first == VID_OFF) begin
          f_bold = 0; f_inv = 0; f_under = 0;
        end
      end
      ACT_SHOW: f_show = 1;
      ACT_HIDE: f_show = 0;
      ACT_READ: cell_val = scr[(sat(a1, NROW)-1)*NCOL + sat(a2, NCOL)-1];
      default: ;
    endcase
    o.cell_code = cell_val;
    o.cursor_row = 5'(cur_row);
    o.cursor_col = 7'(cur_col);
    o.bold_on = f_bold;
    o.inverse_on = f_inv;
    o.underline_on = f_under;
    o.cursor_shown = f_show;
    return o;
  endfunction

  function automatic in_req_t mk(logic [4:0] a, int c, int a1, int a2);
    in_req_t q;
    q.action = a;
    q.code = 8'(c);
    q.arg_first = 8'(a1);
    q.arg_second = 8'(a2);
    return q;
  endfunction

  // Weighted so the cursor runs into scrolls, wraps and region edges often.
  function automatic in_req_t random_command();
    int p;
    int a1;
    p = $urandom_range(0, 99);
    a1 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9);
    if (p < 30) return mk(ACT_CHAR, $urandom_range(0, 255), $urandom, $urandom);
    if (p < 38) return mk(ACT_LF, 0, 0, 0);
    if (p < 45) return mk(ACT_TAB, 0, 0, 0);
    if (p < 60) return mk(ACT_READ, 0, $urandom_range(0, 27), $urandom_range(0, 83));
    if (p < 64) return mk(ACT_POS, 0, $urandom_range(0, 27), $urandom_range(0, 83));
    if (p < 66) return mk(ACT_REGION, 0, $urandom_range(0, 27), $urandom_range(0, 27));
    if (p < 68) return mk(ACT_ERASE_LINE, 0, $urandom_range(0, 3), $urandom);
    if (p < 69) return mk(ACT_ERASE_DISP, 0, $urandom_range(0, 3), $urandom);
    if (p < 72) return mk(ACT_VIDEO, 0, ($urandom_range(0, 1) ? a1 : $urandom), $urandom);
    if (p < 96) return mk(5'($urandom_range(ACT_CR, ACT_HIDE)), $urandom, a1, $urandom);
    return mk(5'($urandom_range(0, 31)), $urandom, $urandom, $urandom);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) expected_status.push_back(apply_command(in_data));
      if (pending_cmds.size() != 0 && !drain_hold &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("result with no request pending");
          failed = 1;
        end else begin
          out_req_t e;
          e = expected_status.pop_front();
          if (out_data.cell_code !== e.cell_code) begin
            $error("cell_code exp %0d got %0d", e.cell_code, out_data.cell_code); failed = 1;
          end
          if (out_data.cursor_row !== e.cursor_row) begin
            $error("cursor_row exp %0d got %0d", e.cursor_row, out_data.cursor_row); failed = 1;
          end
          if (out_data.cursor_col !== e.cursor_col) begin
            $error("cursor_col exp %0d got %0d", e.cursor_col, out_data.cursor_col); failed = 1;
          end
          if (out_data.bold_on !== e.bold_on) begin
            $error("bold_on exp %0b got %0b", e.bold_on, out_data.bold_on); failed = 1;
          end
          if (out_data.inverse_on !== e.inverse_on) begin
            $error("inverse_on exp %0b got %0b", e.inverse_on, out_data.inverse_on); failed = 1;
          end
          if (out_data.underline_on !== e.underline_on) begin
            $error("underline_on exp %0b got %0b", e.underline_on, out_data.underline_on);
            failed = 1;
          end
          if (out_data.cursor_shown !== e.cursor_shown) begin
            $error("cursor_shown exp %0b got %0b", e.cursor_shown, out_data.cursor_shown);
            failed = 1;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic run_phase(int n, int s_idle, int r_stall);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    for (int i = 0; i < n; i++) pending_cmds.push_back(random_command());
    wait (pending_cmds.size() == 0);
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    failed = 0;
    drain_hold = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    screen_reset();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    pending_cmds.push_back(mk(ACT_READ, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 255, 255));
    pending_cmds.push_back(mk(ACT_POS, 0, 25, 79));
    pending_cmds.push_back(mk(ACT_CHAR, 8'hFF, 8'hFF, 8'hFF));
    pending_cmds.push_back(mk(ACT_CHAR, 8'h00, 0, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 25, 80));
    pending_cmds.push_back(mk(ACT_READ, 0, 24, 80));
    pending_cmds.push_back(mk(ACT_TAB, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_BS, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_CR, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_BS, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_UP, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_DOWN, 0, 255, 0));
    pending_cmds.push_back(mk(ACT_RIGHT, 0, 255, 0));
    pending_cmds.push_back(mk(ACT_LEFT, 0, 3, 0));
    pending_cmds.push_back(mk(ACT_REGION, 0, 20, 5));
    pending_cmds.push_back(mk(ACT_LF, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_REGION, 0, 3, 10));
    pending_cmds.push_back(mk(ACT_LF, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_ERASE_LINE, 0, 1, 0));
    pending_cmds.push_back(mk(ACT_ERASE_DISP, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_VIDEO, 0, 7, 0));
    pending_cmds.push_back(mk(ACT_VIDEO, 0, 1, 0));
    pending_cmds.push_back(mk(ACT_VIDEO, 0, 4, 0));
    pending_cmds.push_back(mk(ACT_HIDE, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_SHOW, 0, 0, 0));
    pending_cmds.push_back(mk(5'd31, 8'hFF, 8'hFF, 8'hFF));
    pending_cmds.push_back(mk(ACT_VIDEO, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_ERASE_DISP, 0, 2, 0));
    wait (pending_cmds.size() == 0);

    run_phase(300, 0, 0);
    run_phase(250, 84, 0);
    wait (expected_status.size() == 0 && !in_valid);
    drain_hold = 1;
    wait (expected_status.size() == 0 && !in_valid);
    drain_hold = 0;
    run_phase(250, 0, 84);
    run_phase(250, 13, 13);
    run_phase(100, 0, 0);

    wait (!in_valid && expected_status.size() == 0);
    repeat (200) @(posedge clk);
    if (!failed && expected_status.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
